// ===== sv/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared widths, codes and control structs of the central FCFS dispatcher.
// ----------------------------------------------------------------------------
package cfd_pkg;

  // Default sizing
  localparam int CPU_COUNT_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 64;

  // Field widths
  localparam int CMD_W      = 3;
  localparam int TASK_W     = 16;
  localparam int WIDX_W     = 4;
  localparam int TIME_W     = 48;
  localparam int ST_W       = 2;
  localparam int PH_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int QUANT_W    = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_SPAWN    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PREEMPT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POLL     = 3'd4;

  // Worker phases
  localparam logic [PH_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PH_W-1:0] PH_QUEUING   = 3'd1;
  localparam logic [PH_W-1:0] PH_RUNNING   = 3'd2;
  localparam logic [PH_W-1:0] PH_FINISHED  = 3'd3;
  localparam logic [PH_W-1:0] PH_PREEMPTED = 3'd4;

  // Result status
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_IDX  = 2'd2;
  localparam logic [ST_W-1:0] ST_KEPT     = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM      = 2'd1;

  // Controller to datapath
  typedef struct packed {
    logic              latch;   // capture input item
    logic              exec;    // run a single-result command
    logic              poll_a;  // poll visit, first cycle
    logic              poll_b;  // poll visit, result cycle
    logic              last;    // final result of this item
    logic [WIDX_W-1:0] idx;     // worker being polled
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;       // latched command
    logic [WIDX_W-1:0] n_workers; // workers to poll
    logic              out_free;  // result register can load
  } dp_status_t;

endpackage

// ===== sv/cfd_if.sv =====
// ----------------------------------------------------------------------------
// cfd_if
// Valid/ready channels of the dispatcher: input items, results, config.
// ----------------------------------------------------------------------------
interface cfd_in_if;
  logic                        valid;
  logic                        ready;
  logic [cfd_pkg::CMD_W-1:0]   command;
  logic [cfd_pkg::TASK_W-1:0]  task_id;
  logic [cfd_pkg::WIDX_W-1:0]  worker_index;
  logic [cfd_pkg::TIME_W-1:0]  now_time;
  modport source (output valid, command, task_id, worker_index, now_time, input ready);
  modport sink   (input valid, command, task_id, worker_index, now_time, output ready);
endinterface

interface cfd_out_if;
  logic                        valid;
  logic                        ready;
  logic [cfd_pkg::WIDX_W-1:0]  worker_slot;
  logic                        assign_valid;
  logic [cfd_pkg::TASK_W-1:0]  assigned_task;
  logic                        free_valid;
  logic [cfd_pkg::TASK_W-1:0]  freed_task;
  logic                        preempt_send;
  logic [cfd_pkg::ST_W-1:0]    status;
  logic                        last_result;
  modport source (output valid, worker_slot, assign_valid, assigned_task, free_valid,
                  freed_task, preempt_send, status, last_result, input ready);
  modport sink   (input valid, worker_slot, assign_valid, assigned_task, free_valid,
                  freed_task, preempt_send, status, last_result, output ready);
endinterface

interface cfd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cfd_pkg::CFG_IDX_W-1:0]   index;
  logic [cfd_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/central_fcfs_dispatcher_top.sv =====
// ----------------------------------------------------------------------------
// central_fcfs_dispatcher_top
// Single-queue FCFS dispatcher with a preemption quantum.
// ----------------------------------------------------------------------------
// Spawn and worker events: an item is accepted in the idle state, then executed
// in the exec state once the result register is free. Poll: a visit state (queue
// RAM read), then a result state, per polled worker; results held off stall it.
// Reset (rst_ni low, asynchronous) idles all workers, empties the queue and
// loads worker_count with min(15, CPU_COUNT-1); no clearing pass is needed.
// ----------------------------------------------------------------------------
module central_fcfs_dispatcher_top #(
  parameter int CpuCount   = cfd_pkg::CPU_COUNT_DEF,
  parameter int QueueDepth = cfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfd_in_if.sink      in_s,
  cfd_out_if.source   out_m,
  cfd_cfg_if.sink     cfg_s
);

  cfd_pkg::ctrl_cmd_t  ctrl_cmd;
  cfd_pkg::dp_status_t dp_status;
  logic                in_ready;

  // Sequencer
  cfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_s.valid),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  // Datapath; it drives in_s.ready from the latch command
  cfd_datapath #(.CpuCount(CpuCount), .QueueDepth(QueueDepth)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_s     (in_s),
    .out_m    (out_m),
    .cfg_s    (cfg_s),
    .cmd_i    (ctrl_cmd),
    .status_o (dp_status)
  );

  // Latch is raised only while the sequencer is ready
  a_latch_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.latch |-> in_ready)
    else $error("item latched while busy");

endmodule

// ===== sv/cfd_ram.sv =====
// ----------------------------------------------------------------------------
// cfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfd_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write, and register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/cfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfd_ctrl
// Sequencer: accepts items, runs single-result commands, steps the poll.
// ----------------------------------------------------------------------------
module cfd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  cfd_pkg::dp_status_t    status_i,
  output cfd_pkg::ctrl_cmd_t     cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_POLL_A = 2'd2;
  localparam logic [1:0] S_POLL_B = 2'd3;

  logic [1:0]                 state_q, state_d;
  logic [cfd_pkg::WIDX_W-1:0] idx_q, idx_d;
  logic                       is_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign is_last    = (idx_q == status_i.n_workers);

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cmd_o        = '0;
    cmd_o.idx    = idx_q;
    cmd_o.last   = is_last;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status_i.cmd)
          cfd_pkg::CMD_SPAWN, cfd_pkg::CMD_BEGIN,
          cfd_pkg::CMD_FINISH, cfd_pkg::CMD_PREEMPT: begin
            if (status_i.out_free) begin
              cmd_o.exec = 1'b1;
              state_d    = S_IDLE;
            end
          end
          cfd_pkg::CMD_POLL: begin
            if (status_i.n_workers == '0) begin
              state_d = S_IDLE;
            end else begin
              idx_d   = cfd_pkg::WIDX_W'(1);
              state_d = S_POLL_A;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_POLL_A: begin
        cmd_o.poll_a = 1'b1;
        state_d      = S_POLL_B;
      end
      S_POLL_B: begin
        if (status_i.out_free) begin
          cmd_o.poll_b = 1'b1;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + cfd_pkg::WIDX_W'(1);
            state_d = S_POLL_A;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // A poll result always follows the first visit cycle
  a_poll_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.poll_b |-> ($past(state_q) == S_POLL_A || $past(state_q) == S_POLL_B))
    else $error("poll result without visit");

  // Polled index stays within 1..n
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.poll_a || cmd_o.poll_b) |-> (idx_q != '0 && idx_q <= status_i.n_workers))
    else $error("poll index out of range");

endmodule

// ===== sv/cfd_datapath.sv =====
// ----------------------------------------------------------------------------
// cfd_datapath
// Worker table, task queue, config registers and result register.
// ----------------------------------------------------------------------------
module cfd_datapath #(
  parameter int CpuCount   = cfd_pkg::CPU_COUNT_DEF,
  parameter int QueueDepth = cfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cfd_in_if.sink               in_s,
  cfd_out_if.source            out_m,
  cfd_cfg_if.sink              cfg_s,
  input  cfd_pkg::ctrl_cmd_t   cmd_i,
  output cfd_pkg::dp_status_t  status_o
);

  // Worker slots reachable through a 4-bit index
  localparam int NumW  = (CpuCount < 16) ? CpuCount : 16;
  localparam int IdxW  = $clog2(NumW);
  localparam int QAw   = $clog2(QueueDepth);
  localparam int WcRst = (15 < CpuCount - 1) ? 15 : CpuCount - 1;

  // Latched item
  logic [cfd_pkg::CMD_W-1:0]  cmd_q;
  logic [cfd_pkg::TASK_W-1:0] task_q;
  logic [cfd_pkg::WIDX_W-1:0] widx_q;
  logic [cfd_pkg::TIME_W-1:0] now_q;

  // Config
  logic [cfd_pkg::WIDX_W-1:0]  wcount_q;
  logic [cfd_pkg::QUANT_W-1:0] quantum_q;

  // Worker table
  logic [cfd_pkg::PH_W-1:0]   phase_q [NumW];
  logic [cfd_pkg::TASK_W-1:0] wtask_q [NumW];
  logic [cfd_pkg::TIME_W-1:0] start_q [NumW];
  logic [NumW-1:0]            mark_q;
  logic                       claimed_q;

  // Queue pointers
  logic [QAw-1:0] head_q, tail_q;
  logic [QAw:0]   count_q;
  logic           pushed_q, push_fail_q, was_empty_q;

  // Result register
  logic                       ovalid_q;
  logic [cfd_pkg::WIDX_W-1:0] oslot_q;
  logic                       oav_q, ofv_q, ops_q, olast_q;
  logic [cfd_pkg::TASK_W-1:0] oat_q, oft_q;
  logic [cfd_pkg::ST_W-1:0]   ost_q;

  // RAM port
  logic                       ram_we;
  logic [cfd_pkg::TASK_W-1:0] ram_wdata, ram_rdata;

  logic [IdxW-1:0]            pi, ei;
  logic [cfd_pkg::PH_W-1:0]   ph;
  logic                       q_full, q_empty, out_free, ev_bad, preempt_due;
  logic [cfd_pkg::TASK_W-1:0] popped;
  logic [QAw-1:0]             tail_inc, head_inc;

  assign pi      = cmd_i.idx[IdxW-1:0];
  assign ei      = widx_q[IdxW-1:0];
  assign ph      = phase_q[pi];
  assign q_full  = (count_q == (QAw+1)'(QueueDepth));
  assign q_empty = (count_q == '0);
  assign out_free = !ovalid_q || out_m.ready;
  assign ev_bad  = (widx_q == '0) || (int'(widx_q) >= CpuCount);
  assign tail_inc = (int'(tail_q) == QueueDepth - 1) ? '0 : tail_q + QAw'(1);
  assign head_inc = (int'(head_q) == QueueDepth - 1) ? '0 : head_q + QAw'(1);
  assign preempt_due = (quantum_q != '0) && !mark_q[pi] &&
      ({1'b0, now_q} > ({1'b0, start_q[pi]} + {17'b0, quantum_q}));
  // A task pushed onto an empty queue is popped straight back
  assign popped  = (was_empty_q && pushed_q) ? wtask_q[pi] : ram_rdata;

  assign in_s.ready  = cmd_i.latch;
  assign cfg_s.ready = 1'b1;

  assign status_o.cmd       = cmd_q;
  assign status_o.n_workers = wcount_q;
  assign status_o.out_free  = out_free;

  // Queue write port: spawn push or requeue of a preempted task
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = task_q;
    if (cmd_i.exec && cmd_q == cfd_pkg::CMD_SPAWN && claimed_q && !q_full) begin
      ram_we = 1'b1;
    end else if (cmd_i.poll_a && ph == cfd_pkg::PH_PREEMPTED && !q_full) begin
      ram_we    = 1'b1;
      ram_wdata = wtask_q[pi];
    end
  end

  cfd_ram #(.Width(cfd_pkg::TASK_W), .Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch && in_s.valid) begin
      cmd_q  <= in_s.command;
      task_q <= in_s.task_id;
      widx_q <= in_s.worker_index;
      now_q  <= in_s.now_time;
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q  <= cfd_pkg::WIDX_W'(WcRst);
      quantum_q <= '0;
    end else if (cfg_s.valid) begin
      if (cfg_s.index == cfd_pkg::REG_WORKER_COUNT) begin
        if (int'(cfg_s.data[cfd_pkg::WIDX_W-1:0]) < CpuCount) begin
          wcount_q <= cfg_s.data[cfd_pkg::WIDX_W-1:0];
        end
      end else if (cfg_s.index == cfd_pkg::REG_QUANTUM) begin
        quantum_q <= cfg_s.data[cfd_pkg::QUANT_W-1:0];
      end
    end
  end

  // Worker table, queue pointers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumW; k++) begin
        phase_q[k] <= cfd_pkg::PH_IDLE;
        wtask_q[k] <= '0;
        start_q[k] <= '0;
      end
      mark_q      <= '0;
      claimed_q   <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      pushed_q    <= 1'b0;
      push_fail_q <= 1'b0;
      was_empty_q <= 1'b0;
      ovalid_q    <= 1'b0;
      oslot_q     <= '0;
      oav_q       <= 1'b0;
      oat_q       <= '0;
      ofv_q       <= 1'b0;
      oft_q       <= '0;
      ops_q       <= 1'b0;
      ost_q       <= cfd_pkg::ST_OK;
      olast_q     <= 1'b0;
    end else begin
      // Drop the result once transferred
      if (out_m.ready && !cmd_i.exec && !cmd_i.poll_b) begin
        ovalid_q <= 1'b0;
      end

      if (cmd_i.exec) begin
        ovalid_q <= 1'b1;
        oav_q    <= 1'b0;
        oat_q    <= '0;
        ofv_q    <= 1'b0;
        oft_q    <= '0;
        ops_q    <= 1'b0;
        olast_q  <= 1'b1;
        if (cmd_q == cfd_pkg::CMD_SPAWN) begin
          oslot_q <= '0;
          if (!claimed_q) begin
            claimed_q  <= 1'b1;
            wtask_q[0] <= task_q;
            phase_q[0] <= cfd_pkg::PH_QUEUING;
            ost_q      <= cfd_pkg::ST_KEPT;
          end else if (q_full) begin
            ost_q <= cfd_pkg::ST_FULL;
          end else begin
            tail_q  <= tail_inc;
            count_q <= count_q + (QAw+1)'(1);
            ost_q   <= cfd_pkg::ST_OK;
          end
        end else begin
          oslot_q <= widx_q;
          if (ev_bad) begin
            ost_q <= cfd_pkg::ST_BAD_IDX;
          end else begin
            ost_q <= cfd_pkg::ST_OK;
            case (cmd_q)
              cfd_pkg::CMD_BEGIN: begin
                phase_q[ei] <= cfd_pkg::PH_RUNNING;
                start_q[ei] <= now_q;
              end
              cfd_pkg::CMD_FINISH:  phase_q[ei] <= cfd_pkg::PH_FINISHED;
              default:              phase_q[ei] <= cfd_pkg::PH_PREEMPTED;
            endcase
          end
        end
      end

      // First visit cycle: requeue a preempted task, read the head
      if (cmd_i.poll_a) begin
        was_empty_q <= q_empty;
        pushed_q    <= 1'b0;
        push_fail_q <= 1'b0;
        if (ph == cfd_pkg::PH_PREEMPTED) begin
          if (q_full) begin
            push_fail_q <= 1'b1;
          end else begin
            pushed_q <= 1'b1;
            tail_q   <= tail_inc;
            count_q  <= count_q + (QAw+1)'(1);
          end
        end
      end

      // Result cycle of a visit
      if (cmd_i.poll_b) begin
        ovalid_q <= 1'b1;
        oslot_q  <= cmd_i.idx;
        olast_q  <= cmd_i.last;
        oav_q    <= 1'b0;
        oat_q    <= '0;
        ofv_q    <= 1'b0;
        oft_q    <= '0;
        ops_q    <= 1'b0;
        ost_q    <= cfd_pkg::ST_OK;
        if (ph == cfd_pkg::PH_RUNNING) begin
          if (preempt_due) begin
            ops_q      <= 1'b1;
            mark_q[pi] <= 1'b1;
          end
        end else if (ph != cfd_pkg::PH_QUEUING) begin
          if (ph == cfd_pkg::PH_FINISHED) begin
            ofv_q <= 1'b1;
            oft_q <= wtask_q[pi];
          end else if (ph == cfd_pkg::PH_PREEMPTED && push_fail_q) begin
            ost_q <= cfd_pkg::ST_FULL;
          end
          if (!q_empty) begin
            head_q      <= head_inc;
            count_q     <= count_q - (QAw+1)'(1);
            wtask_q[pi] <= popped;
            phase_q[pi] <= cfd_pkg::PH_QUEUING;
            mark_q[pi]  <= 1'b0;
            oav_q       <= 1'b1;
            oat_q       <= popped;
          end else begin
            phase_q[pi] <= cfd_pkg::PH_IDLE;
          end
        end
      end
    end
  end

  assign out_m.valid         = ovalid_q;
  assign out_m.worker_slot   = oslot_q;
  assign out_m.assign_valid  = oav_q;
  assign out_m.assigned_task = oat_q;
  assign out_m.free_valid    = ofv_q;
  assign out_m.freed_task    = oft_q;
  assign out_m.preempt_send  = ops_q;
  assign out_m.status        = ost_q;
  assign out_m.last_result   = olast_q;

  // Queue occupancy never passes its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QAw+1)'(QueueDepth))
    else $error("queue count overflow");

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec || cmd_i.poll_b) |-> out_free)
    else $error("result overwritten");

  // The dispatcher claim is sticky
  a_claim_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(claimed_q) |-> claimed_q)
    else $error("dispatcher claim lost");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the central FCFS dispatcher: directed table, then
// random spawn/event/poll traffic, checked against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int NCPU    = cfd_pkg::CPU_COUNT_DEF;
  localparam int QDEPTH  = cfd_pkg::QUEUE_DEPTH_DEF;
  localparam int LIMIT   = 400000;
  localparam int NRAND   = 10;

  // Command codes outside the defined set
  localparam logic [cfd_pkg::CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
  localparam logic [cfd_pkg::CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [cfd_pkg::WIDX_W-1:0] slot;
    logic                       av;
    logic [cfd_pkg::TASK_W-1:0] at;
    logic                       fv;
    logic [cfd_pkg::TASK_W-1:0] ft;
    logic                       ps;
    logic [cfd_pkg::ST_W-1:0]   st;
    logic                       last;
  } result_t;

  typedef struct {
    logic [cfd_pkg::CMD_W-1:0]  cmd;
    logic [cfd_pkg::TASK_W-1:0] tid;
    logic [cfd_pkg::WIDX_W-1:0] widx;
    logic [cfd_pkg::TIME_W-1:0] now;
    bit                         typed;   // expected status given in the row
    logic [cfd_pkg::ST_W-1:0]   st;
  } row_t;

  logic clk_i, rst_ni;
  cfd_in_if  in_c ();
  cfd_out_if out_c ();
  cfd_cfg_if cfg_c ();

  central_fcfs_dispatcher_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_s(in_c), .out_m(out_c), .cfg_s(cfg_c)
  );

  // Predictor state
  logic [3:0]                 p_count;
  logic [31:0]                p_quantum;
  logic [cfd_pkg::PH_W-1:0]   p_phase [NCPU];
  logic [cfd_pkg::TASK_W-1:0] p_task  [NCPU];
  logic [cfd_pkg::TIME_W-1:0] p_start [NCPU];
  bit                         p_mark  [NCPU];
  logic [cfd_pkg::TASK_W-1:0] p_queue [$];
  bit                         p_claimed;

  result_t pending_results [$];
  int errors = 0;
  int n_results = 0;
  int cycles = 0;
  bit idle_off = 0;
  bit hold_out = 0;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic result_t mk(logic [3:0] s, logic av, logic [15:0] at, logic fv,
                                 logic [15:0] ft, logic ps, logic [1:0] st, logic l);
    result_t r;
    r.slot = s; r.av = av; r.at = at; r.fv = fv; r.ft = ft;
    r.ps = ps; r.st = st; r.last = l;
    return r;
  endfunction

  // Compute the results of one accepted item and advance predictor state
  task automatic dispatch_predict(logic [2:0] c, logic [15:0] t, logic [3:0] w,
                                  logic [47:0] now);
    logic [1:0] st;
    logic av, fv, ps;
    logic [15:0] at, ft;
    logic [49:0] lim;
    if (c == cfd_pkg::CMD_SPAWN) begin
      if (!p_claimed) begin
        p_claimed = 1; p_task[0] = t; p_phase[0] = cfd_pkg::PH_QUEUING;
        st = cfd_pkg::ST_KEPT;
      end else if (p_queue.size() >= QDEPTH) begin
        st = cfd_pkg::ST_FULL;
      end else begin
        p_queue.push_back(t); st = cfd_pkg::ST_OK;
      end
      pending_results.push_back(mk(4'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0, st, 1'b1));
    end else if (c == cfd_pkg::CMD_BEGIN || c == cfd_pkg::CMD_FINISH ||
                 c == cfd_pkg::CMD_PREEMPT) begin
      if (w == 4'd0 || int'(w) >= NCPU) begin
        pending_results.push_back(mk(w, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0,
                                     cfd_pkg::ST_BAD_IDX, 1'b1));
      end else begin
        if (c == cfd_pkg::CMD_BEGIN) begin
          p_phase[w] = cfd_pkg::PH_RUNNING; p_start[w] = now;
        end else if (c == cfd_pkg::CMD_FINISH) p_phase[w] = cfd_pkg::PH_FINISHED;
        else p_phase[w] = cfd_pkg::PH_PREEMPTED;
        pending_results.push_back(mk(w, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0,
                                     cfd_pkg::ST_OK, 1'b1));
      end
    end else if (c == cfd_pkg::CMD_POLL) begin
      for (int i = 1; i <= int'(p_count); i++) begin
        av = 0; at = 0; fv = 0; ft = 0; ps = 0; st = cfd_pkg::ST_OK;
        if (p_phase[i] == cfd_pkg::PH_RUNNING) begin
          lim = {2'b0, p_start[i]} + {18'b0, p_quantum};
          if (p_quantum != 0 && !p_mark[i] && {2'b0, now} > lim) begin
            ps = 1; p_mark[i] = 1;
          end
        end else if (p_phase[i] != cfd_pkg::PH_QUEUING) begin
          if (p_phase[i] == cfd_pkg::PH_FINISHED) begin
            fv = 1; ft = p_task[i];
          end else if (p_phase[i] == cfd_pkg::PH_PREEMPTED) begin
            if (p_queue.size() >= QDEPTH) st = cfd_pkg::ST_FULL;
            else p_queue.push_back(p_task[i]);
          end
          if (p_queue.size() > 0) begin
            at = p_queue.pop_front(); av = 1;
            p_task[i] = at; p_phase[i] = cfd_pkg::PH_QUEUING; p_mark[i] = 0;
          end else p_phase[i] = cfd_pkg::PH_IDLE;
        end
        pending_results.push_back(mk(4'(i), av, at, fv, ft, ps, st, i == int'(p_count)));
      end
    end
  endtask

  // Result side: random stalls, compare each transfer with oldest expectation
  initial begin
    int gap;
    result_t e;
    out_c.ready <= 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_c.valid && out_c.ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $error("unexpected result slot=%0d", out_c.worker_slot); errors++;
        end else begin
          e = pending_results.pop_front();
          if (out_c.worker_slot !== e.slot) begin
            $error("worker_slot exp %0d got %0d", e.slot, out_c.worker_slot); errors++; end
          if (out_c.assign_valid !== e.av) begin
            $error("assign_valid exp %0d got %0d", e.av, out_c.assign_valid); errors++; end
          if (out_c.assigned_task !== e.at) begin
            $error("assigned_task exp %0d got %0d", e.at, out_c.assigned_task); errors++; end
          if (out_c.free_valid !== e.fv) begin
            $error("free_valid exp %0d got %0d", e.fv, out_c.free_valid); errors++; end
          if (out_c.freed_task !== e.ft) begin
            $error("freed_task exp %0d got %0d", e.ft, out_c.freed_task); errors++; end
          if (out_c.preempt_send !== e.ps) begin
            $error("preempt_send exp %0d got %0d", e.ps, out_c.preempt_send); errors++; end
          if (out_c.status !== e.st) begin
            $error("status exp %0d got %0d", e.st, out_c.status); errors++; end
          if (out_c.last_result !== e.last) begin
            $error("last_result exp %0d got %0d", e.last, out_c.last_result); errors++; end
        end
      end
      if (hold_out) out_c.ready <= 0;
      else if (!idle_off && $urandom_range(0, 5) == 0) begin
        out_c.ready <= 0;
        gap = $urandom_range(1, 12);
        repeat (gap - 1) @(posedge clk_i);
      end else out_c.ready <= 1;
    end
  end

  // Send one item; predict at the transfer edge. Valid stays up after the
  // transfer so the next item can follow at once; drain() drops it.
  task automatic send_item(logic [2:0] c, logic [15:0] t, logic [3:0] w, logic [47:0] now);
    if (!idle_off && $urandom_range(0, 4) == 0) begin
      in_c.valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_c.valid <= 1; in_c.command <= c; in_c.task_id <= t;
    in_c.worker_index <= w; in_c.now_time <= now;
    do @(posedge clk_i); while (!in_c.ready);
    dispatch_predict(c, t, w, now);
  endtask

  // One register write, with valid dropped again after it
  task automatic write_reg(logic [cfd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_c.valid <= 1; cfg_c.index <= idx; cfg_c.data <= d;
    do @(posedge clk_i); while (!cfg_c.ready);
    if (idx == cfd_pkg::REG_WORKER_COUNT) begin
      if (int'(d[3:0]) < NCPU) p_count = d[3:0];
    end else if (idx == cfd_pkg::REG_QUANTUM) p_quantum = d;
    cfg_c.valid <= 0;
    @(posedge clk_i);
  endtask

  // Drop valid, wait until all results are in, then let the block settle
  task automatic drain();
    in_c.valid <= 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  row_t rows [$];
  logic [47:0] clock_ns;

  initial begin
    row_t r;
    int c;
    in_c.valid = 0; in_c.command = 0; in_c.task_id = 0;
    in_c.worker_index = 0; in_c.now_time = 0;
    cfg_c.valid = 0; cfg_c.index = 0; cfg_c.data = 0;
    rst_ni = 0;
    p_count = 4'((NCPU - 1 < 15) ? NCPU - 1 : 15);
    p_quantum = 0; p_claimed = 0;
    for (int i = 0; i < NCPU; i++) begin
      p_phase[i] = cfd_pkg::PH_IDLE; p_task[i] = 0; p_start[i] = 0; p_mark[i] = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed table: status typed where obvious, predictor for the rest
    rows = '{
      '{cfd_pkg::CMD_POLL,    16'h0000, 4'd0,  48'd0,              1'b0, cfd_pkg::ST_OK},
      '{cfd_pkg::CMD_SPAWN,   16'hFFFF, 4'd0,  48'd0,              1'b1, cfd_pkg::ST_KEPT},
      '{cfd_pkg::CMD_SPAWN,   16'h0000, 4'd0,  48'd0,              1'b1, cfd_pkg::ST_OK},
      '{cfd_pkg::CMD_SPAWN,   16'hA5A5, 4'd0,  48'd0,              1'b1, cfd_pkg::ST_OK},
      '{cfd_pkg::CMD_BEGIN,   16'h0000, 4'd0,  48'd5,              1'b1, cfd_pkg::ST_BAD_IDX},
      '{cfd_pkg::CMD_FINISH,  16'h0000, 4'd0,  48'd0,              1'b1, cfd_pkg::ST_BAD_IDX},
      '{cfd_pkg::CMD_PREEMPT, 16'h0000, 4'd0,  48'd0,              1'b1, cfd_pkg::ST_BAD_IDX},
      '{CMD_UNDEF_LO,         16'h1234, 4'd3,  48'd0,              1'b0, cfd_pkg::ST_OK},
      '{CMD_UNDEF_HI,         16'hFFFF, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b0, cfd_pkg::ST_OK},
      '{cfd_pkg::CMD_POLL,    16'h0000, 4'd0,  48'd10,             1'b0, cfd_pkg::ST_OK},
      '{cfd_pkg::CMD_BEGIN,   16'h0000, 4'd1,  48'd100,            1'b1, cfd_pkg::ST_OK},
      '{cfd_pkg::CMD_BEGIN,   16'h0000, 4'd15, 48'hFFFF_FFFF_FF00, 1'b1, cfd_pkg::ST_OK},
      '{cfd_pkg::CMD_FINISH,  16'h0000, 4'd2,  48'd0,              1'b1, cfd_pkg::ST_OK},
      '{cfd_pkg::CMD_PREEMPT, 16'h0000, 4'd3,  48'd0,              1'b1, cfd_pkg::ST_OK},
      '{cfd_pkg::CMD_POLL,    16'h0000, 4'd0,  48'hFFFF_FFFF_FFFF, 1'b0, cfd_pkg::ST_OK}
    };
    write_reg(cfd_pkg::REG_QUANTUM, 32'd50);
    foreach (rows[i]) begin
      r = rows[i];
      if (r.typed) begin
        // checked typed value against predictor queue tail after send
        send_item(r.cmd, r.tid, r.widx, r.now);
        if (pending_results[$].st !== r.st) begin
          $error("status exp %0d got %0d", r.st, pending_results[$].st); errors++;
        end
      end else send_item(r.cmd, r.tid, r.widx, r.now);
    end
    drain();

    // Configuration extremes
    write_reg(cfd_pkg::REG_WORKER_COUNT, 32'd0);
    write_reg(cfd_pkg::REG_QUANTUM, 32'hFFFF_FFFF);
    send_item(cfd_pkg::CMD_POLL, 16'd0, 4'd0, 48'hFFFF_FFFF_FFFF);
    drain();
    write_reg(cfd_pkg::REG_WORKER_COUNT, 32'hFFFF_FFFF);
    write_reg(cfd_pkg::REG_WORKER_COUNT, 32'd4);
    write_reg(cfd_pkg::REG_QUANTUM, 32'd200);

    // Backpressure: spawn until the queue overflows, with results held off at first
    hold_out = 1;
    fork
      begin repeat (300) @(posedge clk_i); hold_out = 0; end
      for (int i = 0; i < 70; i++) send_item(cfd_pkg::CMD_SPAWN, 16'($urandom), 4'd0, 48'd0);
    join
    drain();

    // Random traffic with advancing time; settings vary between phases
    clock_ns = 48'd1000;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(cfd_pkg::REG_WORKER_COUNT, 32'd15); write_reg(cfd_pkg::REG_QUANTUM, 32'd0);
        end
        1: begin
          write_reg(cfd_pkg::REG_WORKER_COUNT, 32'd3); write_reg(cfd_pkg::REG_QUANTUM, 32'd300);
        end
        2: begin
          write_reg(cfd_pkg::REG_WORKER_COUNT, 32'd8); write_reg(cfd_pkg::REG_QUANTUM, 32'd1);
        end
        default: begin
          write_reg(cfd_pkg::REG_WORKER_COUNT, 32'd1);
          write_reg(cfd_pkg::REG_QUANTUM, 32'd1000);
          idle_off = 1;
        end
      endcase
      for (int i = 0; i < NRAND; i++) begin
        clock_ns = clock_ns + 48'($urandom_range(0, 800));
        c = $urandom_range(0, 9);
        if ($urandom_range(0, 30) == 0)
          send_item(3'($urandom_range(0, 7)), 16'($urandom), 4'($urandom),
                    48'({$urandom, $urandom}));
        else if (c < 3) send_item(cfd_pkg::CMD_SPAWN, 16'($urandom), 4'd0, clock_ns);
        else if (c < 8)
          send_item(3'($urandom_range(int'(cfd_pkg::CMD_BEGIN), int'(cfd_pkg::CMD_PREEMPT))),
                    16'($urandom), 4'($urandom_range(0, 15)), clock_ns);
        else send_item(cfd_pkg::CMD_POLL, 16'd0, 4'd0, clock_ns);
      end
      drain();
    end

    $display("Covered spawn/queue overflow, worker events, bad indexes, polls over");
    $display("%0d results across worker counts 0..15 and quanta 0..max.", n_results);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== central_fcfs_dispatcher_top.f =====
sv/cfd_pkg.sv
sv/cfd_if.sv
sv/cfd_ram.sv
sv/cfd_ctrl.sv
sv/cfd_datapath.sv
sv/central_fcfs_dispatcher_top.sv
tb/tb.sv
